### design/smallest_three_selector_defines.svh
// ----------------------------------------------------------------------------
// Smallest-three selector assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in rst.
// ----------------------------------------------------------------------------
`ifndef SMALLEST_THREE_SELECTOR_DEFINES_SVH
`define SMALLEST_THREE_SELECTOR_DEFINES_SVH

// Same-cycle implication.
`define STS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("smallest_three_selector: check failed");

// Next-cycle implication.
`define STS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("smallest_three_selector: check failed");

`endif

### design/sts_pkg.sv
// ----------------------------------------------------------------------------
// Smallest-three selector package
// Widths, sizes and link types shared by the cells, the drain and the top.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int SEL_COUNT = 3;
  localparam int VALUE_W   = 32;
  localparam int CNT_W     = $clog2(SEL_COUNT + 1);

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // One kept entry.
  typedef struct packed {
    logic   valid;
    value_t value;
  } entry_t;

  // What a cell shows to its right-hand neighbor.
  typedef struct packed {
    logic   valid;
    value_t value;
    logic   lt;      // The incoming value goes at or before this cell.
  } cell_link_t;

  // Load request from the insertion row into the drain row.
  typedef struct packed {
    logic   load;
    count_t count;
    logic   short_list;
  } drain_load_t;

endpackage

### design/sts_if.sv
// ----------------------------------------------------------------------------
// Smallest-three selector channels
// Valid/ready interfaces for the input list and the selected results.
// ----------------------------------------------------------------------------
interface sts_in_if;
  logic                 valid;
  logic                 ready;
  sts_pkg::value_t      value;
  logic                 end_of_list;

  modport source (output valid, output value, output end_of_list, input ready);
  modport sink   (input valid, input value, input end_of_list, output ready);
endinterface

interface sts_out_if;
  logic                 valid;
  logic                 ready;
  sts_pkg::value_t      selected_value;
  logic                 last_of_run;
  logic                 short_list;

  modport source (output valid, output selected_value, output last_of_run,
                  output short_list, input ready);
  modport sink   (input valid, input selected_value, input last_of_run,
                  input short_list, output ready);
endinterface

### design/smallest_three_selector.sv
// ----------------------------------------------------------------------------
// Smallest-three selector
// Keeps the three smallest values of a list in a row of compare cells and,
// on the final item, sends them out largest first.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                                      Item
// feed     in   value, end_of_list                           one list element
// result   out  selected_value, last_of_run, short_list      one kept value
//
// One input item is taken every cycle; insertion finishes in the cycle it is
// accepted. A final item loads the drain row, which then gives one result
// per cycle while result is ready, so a list of n values sends min(n, 3)
// results. A final item waits while the drain row holds more than the result
// leaving this cycle; other items never wait. Reset empties both rows at once.
// ----------------------------------------------------------------------------
`include "smallest_three_selector_defines.svh"

module smallest_three_selector (
  input  logic      clk,
  input  logic      rst,
  sts_in_if.sink    feed,
  sts_out_if.source result
);
  import sts_pkg::*;

  localparam cell_link_t HEAD_LINK = '{valid: 1'b1, value: '0, lt: 1'b0};

  cell_link_t  cell_link [SEL_COUNT];
  entry_t      ins       [SEL_COUNT];
  value_t      ld_values [SEL_COUNT];
  logic        fire;
  logic        drain_free;
  count_t      ins_count;
  drain_load_t ld;

  assign feed.ready = !feed.end_of_list || drain_free;
  assign fire       = feed.valid && feed.ready;

  for (genvar i = 0; i < SEL_COUNT; i++) begin : g_cell
    sts_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .fire     (fire),
      .clear    (feed.end_of_list),
      .value_in (feed.value),
      .left     ((i == 0) ? HEAD_LINK : cell_link[(i == 0) ? 0 : i-1]),
      .link     (cell_link[i]),
      .ins      (ins[i])
    );
  end

  // Valid entries form a prefix, so their number is a plain count.
  always_comb begin
    logic [SEL_COUNT-1:0] vbits;
    for (int j = 0; j < SEL_COUNT; j++) begin
      vbits[j] = ins[j].valid;
    end
    ins_count = count_t'($countones(vbits));
  end

  // Reverse the ascending row so the drain holds the largest value first.
  always_comb begin
    for (int k = 0; k < SEL_COUNT; k++) begin
      ld_values[k] = '0;
      for (int j = 0; j < SEL_COUNT; j++) begin
        if (j + k + 1 == int'(ins_count)) begin
          ld_values[k] = ins[j].value;
        end
      end
    end
  end

  assign ld = '{load:       fire && feed.end_of_list,
                count:      ins_count,
                short_list: (ins_count < count_t'(SEL_COUNT))};

  sts_drain u_drain (
    .clk       (clk),
    .rst       (rst),
    .ld        (ld),
    .ld_values (ld_values),
    .free      (drain_free),
    .result    (result)
  );

  for (genvar i = 1; i < SEL_COUNT; i++) begin : g_chk
    `STS_ASSERT_IMP(a_sorted, cell_link[i].valid, cell_link[i-1].valid && (cell_link[i-1].value <= cell_link[i].value))
  end
  `STS_ASSERT_NXT(a_cleared, fire && feed.end_of_list, !cell_link[0].valid)
  `STS_ASSERT_IMP(a_load_nonempty, ld.load, ins_count != '0)

endmodule

### design/sts_cell.sv
// ----------------------------------------------------------------------------
// Insertion cell
// Holds one kept value of the ascending row and takes either the new item's
// value, its left neighbor's value, or keeps its own.
// ----------------------------------------------------------------------------
module sts_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic                clear,
  input  sts_pkg::value_t     value_in,
  input  sts_pkg::cell_link_t left,
  output sts_pkg::cell_link_t link,
  output sts_pkg::entry_t     ins
);
  import sts_pkg::*;

  logic   valid;
  value_t value;
  logic   lt;

  // Equal values stay ahead of the new one, so the compare is strict.
  assign lt   = !valid || (value_in < value);
  assign link = '{valid: valid, value: value, lt: lt};

  always_comb begin
    if (!lt) begin
      ins = '{valid: valid, value: value};
    end else if (left.lt) begin
      ins = '{valid: left.valid, value: left.value};
    end else begin
      ins = '{valid: 1'b1, value: value_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (fire) begin
      valid <= clear ? 1'b0 : ins.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      value <= ins.value;
    end
  end

endmodule

### design/sts_drain.sv
// ----------------------------------------------------------------------------
// Result drain
// A row of output cells loaded largest first; each result shifts the row
// one place toward the output.
// ----------------------------------------------------------------------------
`include "smallest_three_selector_defines.svh"

module sts_drain (
  input  logic                 clk,
  input  logic                 rst,
  input  sts_pkg::drain_load_t ld,
  input  sts_pkg::value_t      ld_values [sts_pkg::SEL_COUNT],
  output logic                 free,
  sts_out_if.source            result
);
  import sts_pkg::*;

  value_t vals [SEL_COUNT];
  count_t cnt;
  logic   short_list;
  logic   pop;

  assign pop  = result.valid && result.ready;
  assign free = (cnt == '0) || ((cnt == count_t'(1)) && result.ready);

  assign result.valid          = (cnt != '0);
  assign result.selected_value = vals[0];
  assign result.last_of_run    = (cnt == count_t'(1));
  assign result.short_list     = short_list;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ld.load) begin
      cnt <= ld.count;
    end else if (pop) begin
      cnt <= cnt - count_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      vals       <= ld_values;
      short_list <= ld.short_list;
    end else if (pop) begin
      for (int k = 0; k < SEL_COUNT - 1; k++) begin
        vals[k] <= vals[k+1];
      end
    end
  end

  `STS_ASSERT_IMP(a_cnt_range, 1'b1, cnt <= count_t'(SEL_COUNT))
  `STS_ASSERT_NXT(a_load_count, ld.load, cnt == $past(ld.count))
  `STS_ASSERT_NXT(a_pop_count, pop && !ld.load, cnt == $past(cnt) - count_t'(1))

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// Smallest-three selector testbench
// Feeds lists of signed values, each closed by an end-of-list item, and
// checks every selected value against a predictor that keeps its own sorted
// copy of the three smallest values. A directed table comes first, then
// random lists under four idling phases on the feed and result channels.
// ----------------------------------------------------------------------------
module tb_top;
  import sts_pkg::*;

  typedef struct packed {
    value_t value;
    logic   last;
    logic   is_short;
  } sel_result_t;

  // A row with a typed expectation is a one-element list, so the single
  // result is the value itself with both flags set.
  typedef struct packed {
    value_t value;
    logic   eol;
    logic   typed;
    value_t want;
  } list_row_t;

  logic clk;
  logic rst;

  sts_in_if  feed_if ();
  sts_out_if res_if ();

  smallest_three_selector uut (
    .clk    (clk),
    .rst    (rst),
    .feed   (feed_if.sink),
    .result (res_if.source)
  );

  value_t      low_vals [SEL_COUNT];
  int          low_count;
  sel_result_t expected_results [$];
  sel_result_t oldest;
  int          err_count;
  int          items_sent;
  int          send_idle_pct;
  int          recv_stall_pct;
  list_row_t   dir_rows [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // Insert one value into the sorted copy; on the final item, queue the kept
  // values largest first and clear the copy.
  function automatic void take_item(value_t v, logic eol);
    int          i;
    int          k;
    sel_result_t r;
    if (!(low_count == SEL_COUNT && v >= low_vals[SEL_COUNT-1])) begin
      i = (low_count < SEL_COUNT) ? low_count : SEL_COUNT - 1;
      while (i > 0 && low_vals[i-1] > v) begin
        low_vals[i] = low_vals[i-1];
        i--;
      end
      low_vals[i] = v;
      if (low_count < SEL_COUNT) low_count++;
    end
    if (eol) begin
      for (k = 0; k < low_count; k++) begin
        r.value    = low_vals[low_count-1-k];
        r.last     = (k == low_count - 1);
        r.is_short = (low_count < SEL_COUNT);
        expected_results.push_back(r);
      end
      low_count = 0;
    end
  endfunction

  function automatic value_t pick_value();
    case ($urandom_range(3))
      0:       return value_t'($urandom);
      1:       return value_t'($signed($urandom_range(10)) - 5);
      2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return value_t'($urandom_range(1) ? 32'h7FFF_FFF0 + $urandom_range(15)
                                                 : 32'h8000_0000 + $urandom_range(15));
    endcase
  endfunction

  task automatic send_item(input value_t v, input logic eol, input logic typed,
                           input value_t want);
    int          n0;
    sel_result_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      feed_if.valid <= 1'b0;
      @(posedge clk);
    end
    feed_if.valid       <= 1'b1;
    feed_if.value       <= v;
    feed_if.end_of_list <= eol;
    @(posedge clk);
    while (!feed_if.ready) @(posedge clk);
    items_sent++;
    n0 = expected_results.size();
    take_item(v, eol);
    if (typed) begin
      while (expected_results.size() > n0) void'(expected_results.pop_back());
      r.value    = want;
      r.last     = 1'b1;
      r.is_short = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  // Result side: stall at the phase's rate and check each accepted result.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending, value", res_if.selected_value, 0);
        end else begin
          oldest = expected_results.pop_front();
          if (res_if.selected_value !== oldest.value)
            report_mismatch("selected_value", res_if.selected_value, oldest.value);
          if (res_if.last_of_run !== oldest.last)
            report_mismatch("last_of_run", res_if.last_of_run, oldest.last);
          if (res_if.short_list !== oldest.is_short)
            report_mismatch("short_list", res_if.short_list, oldest.is_short);
        end
      end
      res_if.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int phase;
    int len;
    int j;
    clk                 = 1'b0;
    rst                 = 1'b1;
    feed_if.valid       = 1'b0;
    feed_if.value       = '0;
    feed_if.end_of_list = 1'b0;
    res_if.ready        = 1'b0;
    err_count           = 0;
    items_sent          = 0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    low_count           = 0;
    foreach (low_vals[i]) low_vals[i] = '0;

    // One-element lists at the extremes, zero and minus one.
    dir_rows.push_back('{32'sh7FFF_FFFF, 1'b1, 1'b1, 32'sh7FFF_FFFF});
    dir_rows.push_back('{32'sh8000_0000, 1'b1, 1'b1, 32'sh8000_0000});
    dir_rows.push_back('{32'sh0000_0000, 1'b1, 1'b1, 32'sh0000_0000});
    dir_rows.push_back('{32'shFFFF_FFFF, 1'b1, 1'b1, 32'shFFFF_FFFF});
    // Two-element list, short.
    dir_rows.push_back('{32'sd5,         1'b0, 1'b0, '0});
    dir_rows.push_back('{-32'sd5,        1'b1, 1'b0, '0});
    // Extremes mixed with duplicates of the minimum.
    dir_rows.push_back('{32'sh8000_0000, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sh7FFF_FFFF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sh0000_0000, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sh7FFF_FFFF, 1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sh8000_0000, 1'b1, 1'b0, '0});
    // All equal.
    dir_rows.push_back('{32'sd7,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd7,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd7,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd7,         1'b1, 1'b0, '0});
    // Descending, so the last value displaces the largest kept one.
    dir_rows.push_back('{32'sd4,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd3,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd2,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd1,         1'b1, 1'b0, '0});
    // Full store, then a value equal to the largest kept one.
    dir_rows.push_back('{32'sd1,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd2,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd3,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd3,         1'b1, 1'b0, '0});
    // Exactly three elements, ascending.
    dir_rows.push_back('{-32'sd1,        1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd0,         1'b0, 1'b0, '0});
    dir_rows.push_back('{32'sd1,         1'b1, 1'b0, '0});

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].value, dir_rows[i].eol, dir_rows[i].typed, dir_rows[i].want);

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      while (items_sent < 26 + (phase + 1) * 80) begin
        // Mostly lists long enough to fill the store, some short ones.
        len = ($urandom_range(4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
        for (j = 0; j < len; j++)
          send_item(pick_value(), j == len - 1, 1'b0, '0);
      end
    end
    feed_if.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
